// ----- src/smvm_pkg.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply package
// Shared constants, command codes and the queue entry type.
// ---------------------------------------------------------------------------
package smvm_pkg;

	// Vector store geometry.
	localparam int unsigned VECTOR_DEPTH = 4096;
	localparam int unsigned ADDR_W       = $clog2(VECTOR_DEPTH);
	// Width used to compare an index against the store depth.
	localparam int unsigned CMP_W        = 21;

	// Queue between the front and the back part.
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Saturation limits of the Q32.32 accumulator.
	localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		CMD_WRITE     = 2'd0,
		CMD_ACC       = 2'd1,
		CMD_ACC_CLOSE = 2'd2,
		CMD_CLOSE     = 2'd3
	} command_t;

	// One classified item as it travels from the front to the back part.
	typedef struct packed {
		logic               acc;
		logic               close;
		logic signed [31:0] value;
		logic signed [31:0] vec;
	} entry_t;

endpackage

// ----- src/smvm_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds between reads.
// ---------------------------------------------------------------------------
module smvm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or registered read at one address.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/smvm_front.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply front part
// Accepts items, writes or reads the vector store and hands entries and
// close commands to the queue.
// ---------------------------------------------------------------------------
module smvm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         command,
	input  logic [11:0]        index,
	input  logic signed [31:0] value,
	output logic               push,
	input  logic               full,
	output smvm_pkg::entry_t   entry
);
	import smvm_pkg::*;

	command_t            cmd;
	logic                accept;
	logic                in_range;
	logic [CMP_W-1:0]    index_ext;
	logic                ram_en;
	logic                ram_we;
	logic [31:0]         ram_rdata;
	logic                is_acc;
	logic                advance;

	logic                valid_s1;
	command_t            cmd_s1;
	logic signed [31:0]  value_s1;
	logic                in_range_s1;

	assign cmd       = command_t'(command);
	assign index_ext = CMP_W'(index);
	assign in_range  = index_ext < CMP_W'(VECTOR_DEPTH);

	// Stage one frees itself whenever the queue has room.
	assign advance    = valid_s1 && !full;
	assign item_ready = !valid_s1 || !full;
	assign accept     = item_valid && item_ready;

	// Classify the command for the store access.
	always_comb begin
		unique case (cmd)
			CMD_ACC, CMD_ACC_CLOSE: is_acc = 1'b1;
			default:                is_acc = 1'b0;
		endcase
	end

	assign ram_we = (cmd == CMD_WRITE);
	assign ram_en = accept && in_range && (ram_we || is_acc);

	smvm_ram #(
		.WIDTH(32),
		.DEPTH(VECTOR_DEPTH)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (index_ext[ADDR_W-1:0]),
		.wdata(value),
		.rdata(ram_rdata)
	);

	// Stage one valid bit: only entries and close commands go on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && !ram_we) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload, held while the queue is full.
	always_ff @(posedge clk) begin
		if (accept && !ram_we) begin
			cmd_s1      <= cmd;
			value_s1    <= value;
			in_range_s1 <= in_range;
		end
	end

	// Build the queue entry; the read data holds while stage one waits.
	always_comb begin
		entry.value = value_s1;
		entry.vec   = in_range_s1 ? $signed(ram_rdata) : 32'sd0;
		unique case (cmd_s1)
			CMD_ACC: begin
				entry.acc   = 1'b1;
				entry.close = 1'b0;
			end
			CMD_ACC_CLOSE: begin
				entry.acc   = 1'b1;
				entry.close = 1'b1;
			end
			default: begin
				entry.acc   = 1'b0;
				entry.close = 1'b1;
			end
		endcase
	end

	assign push = advance;

endmodule

// ----- src/smvm_queue.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply queue
// Short first-in first-out buffer that decouples front and back parts.
// ---------------------------------------------------------------------------
module smvm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  smvm_pkg::entry_t      push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output smvm_pkg::entry_t      head
);
	import smvm_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- src/smvm_back.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply back part
// Multiplies each entry by its vector element, accumulates with saturation
// and presents the row result in an output register.
// ---------------------------------------------------------------------------
module smvm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  smvm_pkg::entry_t   head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [19:0]        row_number,
	output logic signed [63:0] row_sum,
	output logic               saturated
);
	import smvm_pkg::*;

	logic               valid_s1;
	logic               close_s1;
	logic signed [63:0] prod_s1;
	logic signed [63:0] prod;

	logic [63:0]        acc_q;
	logic               sat_q;
	logic [19:0]        row_q;
	logic               out_valid_q;
	logic [19:0]        out_row_q;
	logic [63:0]        out_sum_q;
	logic               out_sat_q;

	logic               slot_free;
	logic               consume;
	logic               load;
	logic [63:0]        sum;
	logic               ovf;
	logic [63:0]        new_acc;
	logic               new_sat;

	// Flow control: a close waits for a free output register.
	assign slot_free = !out_valid_q || result_ready;
	assign consume   = valid_s1 && (!close_s1 || slot_free);
	assign load      = !valid_s1 || consume;
	assign pop       = head_valid && load;

	// Product of entry value and vector element; a bare close adds nothing.
	assign prod = head.acc ? (64'(head.value) * 64'(head.vec)) : 64'sd0;

	// Saturating accumulate.
	assign sum     = acc_q + prod_s1;
	assign ovf     = (acc_q[63] ^ sum[63]) & (prod_s1[63] ^ sum[63]);
	assign new_acc = ovf ? (prod_s1[63] ? SUM_MIN : SUM_MAX) : sum;
	assign new_sat = sat_q | ovf;

	// Control state: product stage, accumulator, row counter, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= head_valid;
			end
			if (consume && close_s1) begin
				acc_q       <= '0;
				sat_q       <= 1'b0;
				row_q       <= row_q + 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				if (consume) begin
					acc_q <= new_acc;
					sat_q <= new_sat;
				end
				if (result_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= prod;
			close_s1 <= head.close;
		end
		if (consume && close_s1) begin
			out_row_q <= row_q;
			out_sum_q <= new_acc;
			out_sat_q <= new_sat;
		end
	end

	assign result_valid = out_valid_q;
	assign row_number   = out_row_q;
	assign row_sum      = $signed(out_sum_q);
	assign saturated    = out_sat_q;

endmodule

// ----- src/sparse_matrix_vector_multiply.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply
// Streams a dense vector into a local store, then accumulates sparse row
// entries against it and returns one saturated Q32.32 sum per closed row.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle, set by the single-port vector store, while
// the queue has room. A row result goes through the store read, the queue,
// the multiply and the accumulate into the output register.
// A four-item queue lets the front keep accepting while the output stalls.
// Reset clears accumulator, row counter, flag and all valid bits; the
// vector store is not cleared and must be written before it is read.
// ---------------------------------------------------------------------------
module sparse_matrix_vector_multiply (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         command,
	input  logic [11:0]        index,
	input  logic signed [31:0] value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [19:0]        row_number,
	output logic signed [63:0] row_sum,
	output logic               saturated
);
	import smvm_pkg::*;

	entry_t entry;
	entry_t head;
	logic   head_valid;
	logic   pop;
	logic   push;
	logic   full;

	smvm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.command   (command),
		.index     (index),
		.value     (value),
		.push      (push),
		.full      (full),
		.entry     (entry)
	);

	smvm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(entry),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	smvm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.row_number  (row_number),
		.row_sum     (row_sum),
		.saturated   (saturated)
	);

endmodule

// ----- src/smvm_checker.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply checker
// Port-level assertions on result ordering, row numbering and handshake.
// ---------------------------------------------------------------------------
module smvm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  logic [1:0]         command,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [19:0]        row_number,
	input  logic signed [63:0] row_sum,
	input  logic               saturated
);
	import smvm_pkg::*;

	logic        in_close;
	logic        out_acc;
	logic [3:0]  pending_q;
	logic [19:0] last_row_q;
	logic        seen_q;

	assign in_close = item_valid && item_ready &&
		(command == CMD_ACC_CLOSE || command == CMD_CLOSE);
	assign out_acc  = result_valid && result_ready;

	// Count closing items whose results are still owed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			last_row_q <= '0;
			seen_q     <= 1'b0;
		end else begin
			if (in_close && !out_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_acc && !in_close) begin
				pending_q <= pending_q - 1'b1;
			end
			if (out_acc) begin
				last_row_q <= row_number;
				seen_q     <= 1'b1;
			end
		end
	end

	// A result is only shown when a closing item is owed one.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 4'd0)
		else $error("result shown without a pending closing item");

	// Rows are numbered consecutively.
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q |-> row_number == last_row_q + 20'd1)
		else $error("row number does not follow the previous row");

	// A stalled result stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn before it was taken");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			$stable(row_number) && $stable(row_sum) && $stable(saturated))
		else $error("result payload changed while stalled");

endmodule

bind sparse_matrix_vector_multiply smvm_checker u_checker (.*);

// ----- dv/sparse_matrix_vector_multiply_tb.sv -----
// ---------------------------------------------------------------------------
// Sparse matrix-vector multiply testbench
// Writes vector elements, streams sparse row entries against them and checks
// every closed row (number, saturated Q32.32 sum and flag) against a
// fixed-point prediction kept in a small scoreboard class. A directed opening
// covers the extremes and both saturation directions; random rows and vector
// writes follow, with random idling on both sides and one long output stall.
// ---------------------------------------------------------------------------
module sparse_matrix_vector_multiply_tb;

	import smvm_pkg::*;

	localparam int ITEM_TOTAL  = 850;
	localparam int CALM_ITEMS  = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_TAIL  = 8;

	typedef struct {
		logic [19:0]        number;
		logic signed [63:0] sum;
		logic               sat;
	} row_result_t;

	// Predicts the closed rows and holds them until the block returns them.
	class row_checker;
		logic signed [31:0] vec_mem [VECTOR_DEPTH];
		logic signed [63:0] acc;
		logic [19:0]        row_cnt;
		logic               sat_seen;
		row_result_t        expected_rows [$];
		int                 errors;

		function new();
			acc      = '0;
			row_cnt  = '0;
			sat_seen = 1'b0;
			errors   = 0;
		endfunction

		// Multiply the entry by its vector element and add with saturation.
		function void add_product(logic [11:0] col, logic signed [31:0] entry);
			logic signed [63:0] wide_a, wide_b, prod, total;
			wide_a = entry;
			wide_b = vec_mem[col];
			prod   = wide_a * wide_b;
			total  = acc + prod;
			if (acc[63] == prod[63] && total[63] != acc[63]) begin
				total    = prod[63] ? SUM_MIN : SUM_MAX;
				sat_seen = 1'b1;
			end
			acc = total;
		endfunction

		function void close_row();
			row_result_t r;
			r.number = row_cnt;
			r.sum    = acc;
			r.sat    = sat_seen;
			expected_rows.push_back(r);
			acc      = '0;
			sat_seen = 1'b0;
			row_cnt  = row_cnt + 20'd1;
		endfunction

		function void note_item(command_t c, logic [11:0] i, logic signed [31:0] v);
			case (c)
				CMD_WRITE: vec_mem[i] = v;
				CMD_ACC: add_product(i, v);
				CMD_ACC_CLOSE: begin
					add_product(i, v);
					close_row();
				end
				CMD_CLOSE: close_row();
				default: ;
			endcase
		endfunction

		function void check_row(logic [19:0] number, logic signed [63:0] sum, logic sat);
			row_result_t want;
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected row result: expected none, got row_number %0d, row_sum %h",
					$time, number, sum);
				errors++;
				return;
			end
			want = expected_rows.pop_front();
			if (number !== want.number) begin
				$display("%0t: row_number mismatch: expected %0d, got %0d",
					$time, want.number, number);
				errors++;
			end
			if (sum !== want.sum) begin
				$display("%0t: row_sum mismatch: expected %h, got %h", $time, want.sum, sum);
				errors++;
			end
			if (sat !== want.sat) begin
				$display("%0t: saturated mismatch: expected %b, got %b", $time, want.sat, sat);
				errors++;
			end
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic [1:0]         command;
	logic [11:0]        index;
	logic signed [31:0] value;
	logic               result_valid;
	logic               result_ready;
	logic [19:0]        row_number;
	logic signed [63:0] row_sum;
	logic               saturated;

	row_checker  books;
	int          items_sent;
	bit          calm;
	int          quiet_cycles;
	bit          written [VECTOR_DEPTH];
	logic [11:0] written_list [$];

	sparse_matrix_vector_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.index        (index),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.row_number   (row_number),
		.row_sum      (row_sum),
		.saturated    (saturated)
	);

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one item, wait for it to be taken and record it.
	task automatic send_item(input command_t c, input logic [11:0] i,
			input logic signed [31:0] v);
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid <= 1'b1;
		command    <= c;
		index      <= i;
		value      <= v;
		do @(posedge clk); while (!item_ready);
		books.note_item(c, i, v);
		if (c == CMD_WRITE && !written[i]) begin
			written[i] = 1'b1;
			written_list.push_back(i);
		end
		items_sent++;
		calm = (items_sent >= ITEM_TOTAL - CALM_ITEMS);
	endtask

	// Values weighted towards the extremes and towards small magnitudes.
	function automatic logic signed [31:0] pick_value();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3, 4: return {{14{r[17]}}, r[17:0]};
			default: return r;
		endcase
	endfunction

	// Only columns that already hold a vector element are ever read.
	function automatic logic [11:0] pick_column();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	task automatic send_write_burst();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) send_item(CMD_WRITE, 12'($urandom), pick_value());
	endtask

	// One ordinary row, sometimes with a vector write slipped in between entries.
	task automatic send_row();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 11) == 0)
				send_item(CMD_WRITE, 12'($urandom), pick_value());
			if (k == n - 1 && $urandom_range(0, 1) == 0)
				send_item(CMD_ACC_CLOSE, pick_column(), pick_value());
			else if (k == n - 1)
				send_item(CMD_ACC, pick_column(), pick_value());
			else
				send_item(CMD_ACC, pick_column(), pick_value());
		end
		if (n == 0 || command != CMD_ACC_CLOSE)
			send_item(CMD_CLOSE, 12'($urandom), $urandom);
	endtask

	// A row of extreme entries whose products mostly share one sign, so that
	// the accumulator clamps and then carries on from the clamped value.
	task automatic send_heavy_row();
		int n;
		bit neg, flip;
		logic [11:0] col;
		logic signed [31:0] v;
		n   = $urandom_range(6, 16);
		neg = 1'($urandom_range(0, 1));
		for (int k = 0; k < n; k++) begin
			col  = pick_column();
			flip = ($urandom_range(0, 4) == 0);
			v    = (books.vec_mem[col][31] ^ neg ^ flip) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			if (k == n - 1)
				send_item(CMD_ACC_CLOSE, col, v);
			else
				send_item(CMD_ACC, col, v);
		end
	endtask

	// Output side: random stalls, calm stretches and one long hold-off.
	initial begin
		bit held;
		held         = 1'b0;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && items_sent >= 30) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Check every accepted row result.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			books.check_row(row_number, row_sum, saturated);
	end

	// Watchdog: too long without any item moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Reset, directed opening, random rows and the final drain.
	initial begin
		int pick;
		books        = new();
		items_sent   = 0;
		calm         = 1'b0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		command      = CMD_WRITE;
		index        = '0;
		value        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme vector elements at the lowest and highest addresses, plus two small ones.
		send_item(CMD_WRITE, 12'h000, 32'sh8000_0000);
		send_item(CMD_WRITE, 12'hFFF, 32'sh7FFF_FFFF);
		send_item(CMD_WRITE, 12'hAAA, 32'sh0001_0000);
		send_item(CMD_WRITE, 12'h555, 32'shFFFF_0000);
		// An empty row straight after reset; index and value are ignored.
		send_item(CMD_CLOSE, 12'hFFF, 32'shFFFF_FFFF);
		// Positive saturation, then further additions from the clamped sum.
		send_item(CMD_ACC, 12'h000, 32'sh8000_0000);
		send_item(CMD_ACC, 12'h000, 32'sh8000_0000);
		send_item(CMD_ACC, 12'hFFF, 32'sh8000_0000);
		send_item(CMD_ACC_CLOSE, 12'hAAA, 32'sh0000_0000);
		// Negative saturation, held at the limit by a further negative product.
		send_item(CMD_ACC, 12'h000, 32'sh7FFF_FFFF);
		send_item(CMD_ACC, 12'h000, 32'sh7FFF_FFFF);
		send_item(CMD_ACC, 12'h000, 32'sh7FFF_FFFF);
		send_item(CMD_ACC_CLOSE, 12'h555, 32'sh0001_0000);
		// The flag and the sum must have been cleared by the close.
		send_item(CMD_CLOSE, 12'h000, 32'sh0000_0000);
		send_item(CMD_ACC_CLOSE, 12'hAAA, 32'sh0001_8000);
		send_item(CMD_ACC, 12'h555, 32'sh7FFF_FFFF);
		send_item(CMD_ACC_CLOSE, 12'hFFF, 32'sh7FFF_FFFF);
		// Overwrite an element and use it at once; padding entry of zero.
		send_item(CMD_WRITE, 12'hAAA, 32'sh0000_0000);
		send_item(CMD_ACC, 12'hAAA, 32'shFFFF_FFFF);
		send_item(CMD_ACC_CLOSE, 12'h555, 32'sh0000_0000);

		// Write 32 random store elements before the random rows begin.
		repeat (32) send_item(CMD_WRITE, 12'($urandom), pick_value());
		while (items_sent < ITEM_TOTAL) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				send_write_burst();
			else if (pick == 1)
				send_heavy_row();
			else
				send_row();
		end
		item_valid <= 1'b0;

		while (books.pending() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (books.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/smvm_pkg.sv
src/smvm_ram.sv
src/smvm_front.sv
src/smvm_queue.sv
src/smvm_back.sv
src/sparse_matrix_vector_multiply.sv
src/smvm_checker.sv
dv/sparse_matrix_vector_multiply_tb.sv
